// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LMFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define LMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/lmfb_pkg.sv =====
// Shared constants, opcodes and store request type for the LED matrix chain driver.
package lmfb_pkg;

  localparam int DEVICES = 4;
  localparam int COLS    = 8 * DEVICES;
  localparam int ENTRIES = 8 * DEVICES;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CHIP_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  typedef enum logic [2:0] {
    OP_SET_PIXEL   = 3'd0,
    OP_WRITE_PIXEL = 3'd1,
    OP_OR_COLUMN   = 3'd2,
    OP_CLEAR       = 3'd3,
    OP_COMMIT      = 3'd4,
    OP_REG_ONE     = 3'd5,
    OP_REG_ALL     = 3'd6
  } lmfb_op_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_data;
  } lmfb_req_t;

endpackage

// ===== src/lmfb_store.sv =====
// Frame store: synchronous memory with registered read and per-entry valid bits.
module lmfb_store
  import lmfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lmfb_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0]         mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [7:0]         rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.addr] ? mem[req.addr] : 8'h00;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/led_matrix_frame_buffer_chain_driver_top.sv =====
// Top level of the LED matrix chain driver: command sequencer and output register.
// One command at a time; in_ready is high in idle. A pixel edit reads and then writes
// its byte, a column OR does so for all 8 rows, clear acts at accept, and commit reads
// each byte and then loads it out. Register writes send one word for each chip in turn.
// Output register stalls the sequencer on back-pressure.
// Synchronous reset empties the frame store through its valid bits.
`include "assert_macros.svh"

module led_matrix_frame_buffer_chain_driver_top
  import lmfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [5:0] in_column_x,
  input  logic [2:0] in_row_y,
  input  logic [7:0] in_pixel_data,
  input  logic [2:0] in_chip_index,
  input  logic [3:0] in_reg_address,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_word_address,
  output logic [7:0] out_word_data,
  output logic       out_latch,
  output logic       out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT_RD,
    S_EDIT_WR,
    S_CMT_RD,
    S_CMT_LD,
    S_REG
  } state_t;

  state_t            state_r;
  lmfb_op_t          op_r;
  logic [2:0]        row_r;
  logic [2:0]        bit_r;
  logic [CHIP_W-1:0] chip_r;
  logic [CHIP_W-1:0] frame_r;
  logic [CHIP_W-1:0] tgt_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        data_r;
  logic [3:0]        reg_r;

  logic       out_valid_r;
  logic [3:0] out_addr_r;
  logic [7:0] out_data_r;
  logic       out_latch_r;
  logic       out_last_r;

  lmfb_req_t  req;
  logic [7:0] rd_data;
  logic       accept;
  lmfb_op_t   in_op;
  logic       x_ok;
  logic       chip_ok;
  logic       out_free;
  logic       out_load;
  logic       chip_last;
  logic       frame_last;
  logic       set_bit;
  logic [7:0] mask;
  logic [7:0] edit_byte_nxt;
  logic       reg_hit;
  logic       reg_single;

  assign accept     = in_valid && in_ready;
  assign in_op      = lmfb_op_t'(in_opcode);
  assign x_ok       = {1'b0, in_column_x} < 7'(COLS);
  assign chip_ok    = {1'b0, in_chip_index} < 4'(DEVICES);
  assign out_free   = !out_valid_r || out_ready;
  assign out_load   = out_free && ((state_r == S_CMT_LD) || (state_r == S_REG));
  assign chip_last  = chip_r == CHIP_W'(DEVICES - 1);
  assign frame_last = frame_r == CHIP_W'(DEVICES - 1);
  assign reg_single = op_r == OP_REG_ONE;
  assign reg_hit    = chip_r == (reg_single ? tgt_r : frame_r);

  assign mask    = 8'h80 >> bit_r;
  assign set_bit = (op_r == OP_SET_PIXEL) ||
                   ((op_r == OP_WRITE_PIXEL) && (data_r != 8'h00)) ||
                   ((op_r == OP_OR_COLUMN) && data_r[row_r]);

  always_comb begin
    if (set_bit) begin
      edit_byte_nxt = rd_data | mask;
    end else if (op_r == OP_WRITE_PIXEL) begin
      edit_byte_nxt = rd_data & ~mask;
    end else begin
      edit_byte_nxt = rd_data;
    end
  end

  always_comb begin
    req         = '0;
    req.addr    = addr_r;
    req.wr_data = edit_byte_nxt;
    req.clr     = accept && (in_op == OP_CLEAR);
    req.rd_en   = (state_r == S_EDIT_RD) || (state_r == S_CMT_RD);
    req.wr_en   = state_r == S_EDIT_WR;
  end

  lmfb_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r   <= in_op;
            bit_r  <= in_column_x[2:0];
            data_r <= in_pixel_data;
            reg_r  <= in_reg_address;
            tgt_r  <= CHIP_W'(in_chip_index);
            chip_r <= '0;
            frame_r <= '0;
            case (in_op)
              OP_SET_PIXEL, OP_WRITE_PIXEL: begin
                row_r  <= in_row_y;
                addr_r <= ADDR_W'(32'(in_row_y) * DEVICES + 32'(in_column_x[5:3]));
                if (x_ok) begin
                  state_r <= S_EDIT_RD;
                end
              end
              OP_OR_COLUMN: begin
                row_r  <= 3'd0;
                addr_r <= ADDR_W'(in_column_x[5:3]);
                if (x_ok) begin
                  state_r <= S_EDIT_RD;
                end
              end
              OP_COMMIT: begin
                row_r   <= 3'd0;
                addr_r  <= '0;
                state_r <= S_CMT_RD;
              end
              OP_REG_ONE: begin
                if (chip_ok) begin
                  state_r <= S_REG;
                end
              end
              OP_REG_ALL: begin
                state_r <= S_REG;
              end
              default: begin
              end
            endcase
          end
        end
        S_EDIT_RD: begin
          state_r <= S_EDIT_WR;
        end
        S_EDIT_WR: begin
          if ((op_r == OP_OR_COLUMN) && (row_r != 3'd7)) begin
            row_r   <= row_r + 3'd1;
            addr_r  <= addr_r + ADDR_W'(DEVICES);
            state_r <= S_EDIT_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CMT_RD: begin
          state_r <= S_CMT_LD;
        end
        S_CMT_LD: begin
          if (out_free) begin
            out_addr_r  <= {1'b0, row_r} + 4'd1;
            out_data_r  <= rd_data;
            out_latch_r <= chip_last;
            out_last_r  <= chip_last && (row_r == 3'd7);
            addr_r      <= addr_r + ADDR_W'(1);
            if (chip_last) begin
              chip_r <= '0;
              row_r  <= row_r + 3'd1;
            end else begin
              chip_r <= chip_r + CHIP_W'(1);
            end
            state_r <= (chip_last && (row_r == 3'd7)) ? S_IDLE : S_CMT_RD;
          end
        end
        S_REG: begin
          if (out_free) begin
            out_addr_r  <= reg_hit ? reg_r : 4'd0;
            out_data_r  <= reg_hit ? data_r : 8'h00;
            out_latch_r <= chip_last;
            out_last_r  <= chip_last && (reg_single || frame_last);
            if (chip_last) begin
              chip_r  <= '0;
              frame_r <= frame_r + CHIP_W'(1);
              if (reg_single || frame_last) begin
                state_r <= S_IDLE;
              end
            end else begin
              chip_r <= chip_r + CHIP_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_word_address = out_addr_r;
  assign out_word_data    = out_data_r;
  assign out_latch        = out_latch_r;
  assign out_last         = out_last_r;

  `LMFB_ASSERT_IMP(a_last_has_latch, clk, rst_n, out_valid_r && out_last_r, out_latch_r)
  `LMFB_ASSERT_IMP(a_no_rd_wr_mix, clk, rst_n, req.wr_en, !req.rd_en && !req.clr)
  `LMFB_ASSERT_NEXT(a_read_then_write, clk, rst_n, state_r == S_EDIT_RD, state_r == S_EDIT_WR)
  `LMFB_ASSERT_NEXT(a_commit_read_then_load, clk, rst_n, state_r == S_CMT_RD,
                    state_r == S_CMT_LD)

endmodule
